FILE: hdl/rkf_pkg.sv
// ----------------------------------------------------------------------------
// rkf_pkg
// Types and constants shared by the reactive key fade engine modules.
// ----------------------------------------------------------------------------
package rkf_pkg;

  localparam int KEY_W   = 7;
  localparam int LEVEL_W = 16;
  localparam int TIME_W  = 16;
  localparam int RATE_W  = 16;
  localparam int DEC_W   = TIME_W + RATE_W - 8;
  localparam int MASK_W  = 64;
  localparam int CFG_AW  = 2;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = '1;
  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(512);

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_MASK_LO = 2'd0,
    REG_MASK_HI = 2'd1,
    REG_RATE    = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef struct packed {
    cmd_e               command;
    logic [KEY_W-1:0]   key_index;
    logic [TIME_W-1:0]  tick_time;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] key_weight;
    logic               key_held;
    logic               all_idle;
  } out_t;

  typedef struct packed {
    logic               held;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic               held_inc;
    logic               held_dec;
    logic               fade_inc;
    logic               fade_dec;
    logic               hit;
    logic               hit_held;
    logic [LEVEL_W-1:0] hit_weight;
  } stat_t;

endpackage

FILE: hdl/rkf_cell.sv
// ----------------------------------------------------------------------------
// rkf_cell
// One stage of the key ring: holds one key's held mark and fade level.
// ----------------------------------------------------------------------------
module rkf_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  rkf_pkg::entry_t d,
  output rkf_pkg::entry_t q
);
  import rkf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: hdl/rkf_proc.sv
// ----------------------------------------------------------------------------
// rkf_proc
// Head of the ring: applies the current command to the entry passing by.
// ----------------------------------------------------------------------------
module rkf_proc (
  input  rkf_pkg::cmd_e                 command,
  input  logic                          match,
  input  logic                          enable,
  input  logic [rkf_pkg::DEC_W-1:0]     dec,
  input  rkf_pkg::entry_t               ent_in,
  output rkf_pkg::entry_t               ent_out,
  output rkf_pkg::stat_t                stat
);
  import rkf_pkg::*;

  logic level_nz;
  assign level_nz = (ent_in.level != '0);

  always_comb begin
    ent_out = ent_in;
    stat    = '0;
    case (command)
      CMD_PRESS: begin
        if (match && enable) begin
          ent_out.level = '0;
          ent_out.held  = 1'b1;
          stat.fade_dec = level_nz;
          stat.held_inc = !ent_in.held;
        end
      end
      CMD_RELEASE: begin
        if (match && enable && ent_in.held) begin
          ent_out.held  = 1'b0;
          ent_out.level = FULL_LEVEL;
          stat.held_dec = 1'b1;
          stat.fade_inc = !level_nz;
        end
      end
      CMD_TICK: begin
        if (dec != '0 && level_nz) begin
          if (dec >= DEC_W'(ent_in.level)) begin
            ent_out.level = '0;
            stat.fade_dec = 1'b1;
          end else begin
            ent_out.level = ent_in.level - dec[LEVEL_W-1:0];
          end
        end
      end
      default: begin
        if (match) begin
          stat.hit_weight = ent_in.held ? FULL_LEVEL : ent_in.level;
        end
      end
    endcase
    stat.hit      = match && (command != CMD_TICK);
    stat.hit_held = ent_out.held;
  end

endmodule

FILE: hdl/reactive_key_fade_engine.sv
// ----------------------------------------------------------------------------
// reactive_key_fade_engine
// Per-key reactive lighting table: press, release, tick and read commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; item carries the
// command, key index and tick time. Each item gives exactly one result on
// result, marked by done for one cycle; the receiver cannot stall it.
// The key states sit in a ring of NUM_KEYS cells that, in S_PASS, rotates one
// place per cycle past a single processing head, so every command makes one
// full turn. After accept the block forms the tick decrement (S_MUL), turns
// the ring past the head (S_PASS) and presents the result (S_DONE). A new
// item can be taken the cycle after done, not while busy is high.
// The config channel (cfg_valid/cfg_ready, cfg_addr, cfg_wdata) is always
// ready: 0 mask of keys 0-63, 1 mask of keys 64-127, 2 fade rate (Q8.8).
// Other indexes are ignored. Write it only while the block is idle.
// Reset clears all keys, both counts and the registers to their defaults
// (masks all ones, rate 512); the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
module reactive_key_fade_engine #(
  parameter int NUM_KEYS = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rkf_pkg::in_t                item,
  output logic                        done,
  output rkf_pkg::out_t               result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rkf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [rkf_pkg::MASK_W-1:0]  cfg_wdata
);
  import rkf_pkg::*;

  localparam int PW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_PASS = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [MASK_W-1:0]   mask_lo, mask_hi;
  logic [RATE_W-1:0]   rate;
  cmd_e                cmd;
  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   dt;
  logic [DEC_W-1:0]    dec;
  logic [PW-1:0]       pos;
  logic [CW-1:0]       held_count, fading_count;
  logic [LEVEL_W-1:0]  res_weight;
  logic                res_held;

  logic                accept, shift;
  logic [KEY_W-1:0]    pos_key;
  logic [2*MASK_W-1:0] mask_all;
  logic [TIME_W+RATE_W-1:0] prod;
  entry_t              ring [NUM_KEYS];
  entry_t              head_out;
  stat_t               stat;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign shift     = (state == S_PASS);
  assign cfg_ready = 1'b1;
  assign pos_key   = KEY_W'(pos);
  assign mask_all  = {mask_hi, mask_lo};
  assign prod      = dt * rate;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_MUL;
      S_MUL:  state_next = S_PASS;
      S_PASS: if (pos == '0) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_lo <= '1;
      mask_hi <= '1;
      rate    <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_MASK_LO: mask_lo <= cfg_wdata;
        REG_MASK_HI: mask_hi <= cfg_wdata;
        REG_RATE:    rate    <= cfg_wdata[RATE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= item.command;
      key <= item.key_index;
      dt  <= item.tick_time;
    end
    if (state == S_MUL) begin
      dec <= prod[TIME_W+RATE_W-1:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (state == S_MUL) begin
      pos <= PW'(NUM_KEYS - 1);
    end else if (shift) begin
      pos <= pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= '0;
      fading_count <= '0;
    end else if (shift) begin
      held_count   <= held_count + CW'(stat.held_inc) - CW'(stat.held_dec);
      fading_count <= fading_count + CW'(stat.fade_inc) - CW'(stat.fade_dec);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_weight <= '0;
      res_held   <= 1'b0;
    end else if (shift && stat.hit) begin
      res_weight <= stat.hit_weight;
      res_held   <= stat.hit_held;
    end
  end

  rkf_proc u_proc (
    .command (cmd),
    .match   (pos_key == key),
    .enable  (mask_all[pos_key]),
    .dec     (dec),
    .ent_in  (ring[NUM_KEYS-1]),
    .ent_out (head_out),
    .stat    (stat)
  );

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_ring
    if (i == 0) begin : g_first
      rkf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (head_out),
        .q     (ring[i])
      );
    end else begin : g_rest
      rkf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (ring[i-1]),
        .q     (ring[i])
      );
    end
  end

  assign done              = (state == S_DONE);
  assign result.key_weight = res_weight;
  assign result.key_held   = res_held;
  assign result.all_idle   = (held_count == '0) && (fading_count == '0);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reactive key fade engine. A scoreboard class
// keeps its own copy of the key table and the registers, predicts one result
// per accepted item, and checks each strobed result in order. Stimulus is a
// short directed opening, then phases of random press/release/tick/read items
// mostly over a small pool of keys, each phase under new register settings
// and one of a small table of sender idle rates.
// ----------------------------------------------------------------------------

import rkf_pkg::*;

class key_weight_checker;
  logic [MASK_W-1:0]  mask_lo;
  logic [MASK_W-1:0]  mask_hi;
  logic [RATE_W-1:0]  rate;
  bit                 held_mark [2**KEY_W];
  logic [LEVEL_W-1:0] level [2**KEY_W];
  int                 held_count;
  int                 fading_count;
  out_t               results_due [$];
  int unsigned        key_count;
  int unsigned        mismatches;
  int unsigned        checked;
  int unsigned        commands;
  int unsigned        partial_reads;

  function new(int unsigned keys);
    key_count     = keys;
    mask_lo       = '1;
    mask_hi       = '1;
    rate          = RATE_RESET;
    held_count    = 0;
    fading_count  = 0;
    mismatches    = 0;
    checked       = 0;
    commands      = 0;
    partial_reads = 0;
    foreach (level[i]) begin
      level[i]     = '0;
      held_mark[i] = 1'b0;
    end
  endfunction

  function void write_reg(logic [CFG_AW-1:0] addr, logic [MASK_W-1:0] data);
    case (reg_e'(addr))
      REG_MASK_LO: mask_lo = data;
      REG_MASK_HI: mask_hi = data;
      REG_RATE:    rate = data[RATE_W-1:0];
      default: ;
    endcase
  endfunction

  function bit key_enabled(int unsigned k);
    return (k < 64) ? mask_lo[k] : mask_hi[k - 64];
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  function void note_command(in_t c);
    logic [31:0]      prod;
    logic [DEC_W-1:0] dec;
    int unsigned      k;
    bit               in_range;
    out_t             r;
    k        = c.key_index;
    in_range = k < key_count;
    r        = '0;
    case (c.command)
      CMD_PRESS: begin
        if (in_range && key_enabled(k)) begin
          if (level[k] != 0) begin
            level[k] = '0;
            fading_count--;
          end
          if (!held_mark[k]) begin
            held_mark[k] = 1'b1;
            held_count++;
          end
        end
      end
      CMD_RELEASE: begin
        if (in_range && key_enabled(k) && held_mark[k]) begin
          held_mark[k] = 1'b0;
          held_count--;
          if (level[k] == 0) fading_count++;
          level[k] = FULL_LEVEL;
        end
      end
      CMD_TICK: begin
        prod = 32'(c.tick_time) * 32'(rate);
        dec  = prod[31:8];
        if (dec != 0) begin
          foreach (level[i]) begin
            if (level[i] != 0) begin
              if (dec >= level[i]) begin
                level[i] = '0;
                fading_count--;
              end else begin
                level[i] = level[i] - dec[LEVEL_W-1:0];
              end
            end
          end
        end
      end
      default: begin
        if (in_range) begin
          r.key_weight = held_mark[k] ? FULL_LEVEL : level[k];
          if (r.key_weight != 0 && r.key_weight != FULL_LEVEL) partial_reads++;
        end
      end
    endcase
    if (c.command != CMD_TICK && in_range) r.key_held = held_mark[k];
    r.all_idle = (held_count == 0 && fading_count == 0);
    results_due.push_back(r);
    commands++;
  endfunction

  task report_mismatch(string what, longint got, longint want);
    if (mismatches < 40)
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    mismatches++;
  endtask

  task check_result(out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with none due", got, 0);
      return;
    end
    want = results_due.pop_front();
    checked++;
    if (got.key_weight !== want.key_weight)
      report_mismatch("key_weight", got.key_weight, want.key_weight);
    if (got.key_held !== want.key_held)
      report_mismatch("key_held", got.key_held, want.key_held);
    if (got.all_idle !== want.all_idle)
      report_mismatch("all_idle", got.all_idle, want.all_idle);
  endtask

  task flush_leftover();
    while (results_due.size() != 0) begin
      report_mismatch("result never arrived", 0, results_due.size());
      void'(results_due.pop_front());
    end
  endtask
endclass

module tb_top;

  localparam int unsigned NKEYS     = 128;
  localparam int unsigned LATENCY   = NKEYS + 2;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PER_PHASE = 241;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_t                 item;
  logic                done;
  out_t                result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [MASK_W-1:0]   cfg_wdata;

  key_weight_checker   sb;
  int unsigned         key_pool [8];
  int unsigned         settings_used;
  int unsigned         idle_tbl [4] = '{0, 63, 0, 28};

  reactive_key_fade_engine #(.NUM_KEYS(NKEYS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_command(item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_wdata);
    end
  end

  function automatic in_t cmd_item(cmd_e c, int unsigned k, int unsigned t);
    in_t x;
    x.command   = c;
    x.key_index = k[KEY_W-1:0];
    x.tick_time = t[TIME_W-1:0];
    return x;
  endfunction

  function automatic logic [TIME_W-1:0] tick_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return TIME_W'($urandom_range(255));
    if (r < 85) return TIME_W'($urandom_range(4095));
    return TIME_W'($urandom_range(65535));
  endfunction

  function automatic in_t random_command();
    in_t         x;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? $urandom_range(127) : key_pool[$urandom_range(7)];
    x.key_index = k[KEY_W-1:0];
    x.tick_time = TIME_W'($urandom_range(65535));
    if (r < 8) begin
      x.command = cmd_e'($urandom_range(3));
    end else if (r < 32) begin
      x.command = CMD_PRESS;
    end else if (r < 56) begin
      x.command = CMD_RELEASE;
    end else if (r < 78) begin
      x.command   = CMD_TICK;
      x.tick_time = tick_span();
    end else begin
      x.command = CMD_READ;
    end
    return x;
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask(int unsigned sel);
    case (sel % 4)
      0: return '1;
      1: return {$urandom, $urandom};
      2: return '0;
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate(int unsigned sel);
    case (sel % 5)
      0: return RATE_RESET;
      1: return '1;
      2: return RATE_W'($urandom_range(1, 64));
      3: return RATE_W'($urandom_range(65535));
      default: return '0;
    endcase
  endfunction

  task automatic send_command(in_t c, int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every outstanding result is back and the block is free
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_config(logic [MASK_W-1:0] lo, logic [MASK_W-1:0] hi,
                              logic [RATE_W-1:0] rate);
    reg_e              idx  [4];
    logic [MASK_W-1:0] vals [4];
    settle();
    idx  = '{REG_NONE, REG_MASK_LO, REG_MASK_HI, REG_RATE};
    vals = '{{$urandom, $urandom}, lo, hi, {32'($urandom), 16'($urandom), rate}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned pause_at;
    sb            = new(NKEYS);
    settings_used = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default settings: repeated press, release of a free key, zero and full ticks
    send_command(cmd_item(CMD_READ, 0, 16'hFFFF), 0);
    send_command(cmd_item(CMD_PRESS, 0, 0), 0);
    send_command(cmd_item(CMD_PRESS, 0, 0), 0);
    send_command(cmd_item(CMD_READ, 0, 0), 0);
    send_command(cmd_item(CMD_RELEASE, 0, 0), 0);
    send_command(cmd_item(CMD_RELEASE, 0, 0), 0);
    send_command(cmd_item(CMD_TICK, 0, 0), 0);
    send_command(cmd_item(CMD_TICK, 0, 1), 0);
    send_command(cmd_item(CMD_READ, 0, 0), 0);
    send_command(cmd_item(CMD_PRESS, 127, 0), 0);
    send_command(cmd_item(CMD_RELEASE, 127, 0), 0);
    send_command(cmd_item(CMD_PRESS, 127, 0), 0);
    send_command(cmd_item(CMD_PRESS, 70, 0), 0);
    send_command(cmd_item(CMD_RELEASE, 127, 0), 0);
    send_command(cmd_item(CMD_TICK, 127, 16'hFFFF), 0);
    send_command(cmd_item(CMD_READ, 127, 0), 0);

    // every key disabled, fastest rate: disabled press and disabled release of a held key
    write_config('0, '0, '1);
    send_command(cmd_item(CMD_PRESS, 3, 0), 0);
    send_command(cmd_item(CMD_READ, 3, 0), 0);
    send_command(cmd_item(CMD_RELEASE, 70, 0), 0);
    send_command(cmd_item(CMD_READ, 70, 0), 0);
    send_command(cmd_item(CMD_TICK, 0, 16'hFFFF), 0);

    // zero rate: a fade never moves
    write_config('1, '1, '0);
    send_command(cmd_item(CMD_RELEASE, 70, 0), 0);
    send_command(cmd_item(CMD_TICK, 0, 16'hFFFF), 0);
    send_command(cmd_item(CMD_READ, 70, 0), 0);

    for (int p = 0; p < PHASES; p++) begin
      write_config(pick_mask(p < 4 ? p : $urandom_range(3)),
                   pick_mask(p < 4 ? p + 1 : $urandom_range(3)),
                   pick_rate(p < 5 ? p : $urandom_range(4)));
      foreach (key_pool[i]) key_pool[i] = $urandom_range(127);
      pause_at = $urandom_range(20, 200);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n == pause_at) settle();
        send_command(random_command(), idle_tbl[p % 4]);
      end
    end

    settle();
    repeat (LATENCY + 2) @(posedge clk);
    sb.flush_leftover();
    $display("Ran %0d items under %0d register settings; %0d results checked.",
             sb.commands, settings_used, sb.checked);
    $display("Reads that caught a key mid-fade: %0d", sb.partial_reads);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
